### design/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared sizes, codes and item types for the ring buffer deque.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 2;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int MAX_W = (PTR_W > CNT_W) ? ((PTR_W > IDX_W) ? PTR_W : IDX_W)
                                         : ((CNT_W > IDX_W) ? CNT_W : IDX_W);
  // wide enough for slot + offset before the wrap
  localparam int SUM_W = MAX_W + 1;

  // operation codes
  localparam logic [KIND_W-1:0] K_GET    = 3'd0;
  localparam logic [KIND_W-1:0] K_PUT    = 3'd1;
  localparam logic [KIND_W-1:0] K_PUSH_L = 3'd2;
  localparam logic [KIND_W-1:0] K_PUSH_H = 3'd3;
  localparam logic [KIND_W-1:0] K_POP_L  = 3'd4;
  localparam logic [KIND_W-1:0] K_POP_H  = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } out_item_t;

  // decision of the pointer unit for one operation
  typedef struct packed {
    logic [PTR_W-1:0]  slot;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic              wr;       // write value at slot
    logic              use_rd;   // result comes from the store
  } dec_t;

  // (base + off) mod DEPTH, valid for off < DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [SUM_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + off;
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/rbd_ram.sv
// ----------------------------------------------------------------------------
// rbd_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  wire logic               clk,
  input  wire logic [ADDR_W-1:0]  addr,
  input  wire logic               we,
  input  wire logic [WIDTH_P-1:0] wdata,
  output logic      [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem_r [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/rbd_ptr.sv
// ----------------------------------------------------------------------------
// rbd_ptr
// Head pointer and fill count; decodes an item into slot, status, count.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ptr (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire rbd_pkg::in_item_t item,
  output rbd_pkg::dec_t         dec
);

  logic [rbd_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [rbd_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [rbd_pkg::SUM_W-1:0] idx_ext, fill_ext;

  assign idx_ext  = rbd_pkg::SUM_W'(item.index);
  assign fill_ext = rbd_pkg::SUM_W'(fill_r);

  always_comb begin
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    dec.slot   = head_r;
    dec.status = rbd_pkg::ST_OK;
    dec.wr     = 1'b0;
    dec.use_rd = 1'b0;
    unique case (item.kind)
      rbd_pkg::K_GET, rbd_pkg::K_PUT: begin
        if (idx_ext >= fill_ext) begin
          dec.status = rbd_pkg::ST_RANGE;
        end else begin
          dec.slot   = rbd_pkg::wrap_add(head_r, idx_ext);
          dec.wr     = (item.kind == rbd_pkg::K_PUT);
          dec.use_rd = 1'b1;
        end
      end
      rbd_pkg::K_PUSH_L, rbd_pkg::K_PUSH_H: begin
        if (fill_r == rbd_pkg::CNT_W'(rbd_pkg::DEPTH)) begin
          dec.status = rbd_pkg::ST_FULL;
        end else begin
          if (item.kind == rbd_pkg::K_PUSH_L) begin
            head_nxt = (head_r == '0) ? rbd_pkg::PTR_W'(rbd_pkg::DEPTH - 1)
                                      : head_r - 1'b1;
            dec.slot = head_nxt;
          end else begin
            dec.slot = rbd_pkg::wrap_add(head_r, fill_ext);
          end
          dec.wr   = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      rbd_pkg::K_POP_L, rbd_pkg::K_POP_H: begin
        if (fill_r == '0) begin
          dec.status = rbd_pkg::ST_EMPTY;
        end else begin
          if (item.kind == rbd_pkg::K_POP_L) begin
            dec.slot = head_r;
            head_nxt = rbd_pkg::wrap_add(head_r, rbd_pkg::SUM_W'(1));
          end else begin
            dec.slot = rbd_pkg::wrap_add(head_r, fill_ext - 1'b1);
          end
          dec.use_rd = 1'b1;
          fill_nxt   = fill_r - 1'b1;
        end
      end
      default: begin
        // unused codes: no change
      end
    endcase
    dec.count = fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (accept) begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

### design/ring_buffer_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue over a circular single-port store.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_item: kind, index, value) is taken on a clock edge where
//   start is high and busy is low. Kinds: get, put, push low, push high,
//   pop low, pop high.
//   Each item gives exactly one result on out_item, shown for one cycle
//   with out_valid high. The receiver has no way to stall it.
//   Per item: at the accepting edge the store is read at the slot the
//   pointer unit picked (and head/fill move); in the busy cycle, put and
//   push write back and the result is registered. busy is high during
//   that write, so no new item is taken until the current one is done;
//   the next item sees the completed write and no forwarding is needed
//   on the single RAM port.
//   Errors (full, empty, index out of range) return data zero and leave
//   the queue unchanged; count always shows the fill after the item.
//   Reset (rst_n low, synchronous) empties the queue: head and fill clear.
//   Store contents are not cleared; only data from written slots is ever returned.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_deque (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire rbd_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output rbd_pkg::out_item_t      out_item
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                     state_r;
  rbd_pkg::dec_t              dec;
  rbd_pkg::dec_t              op_r;
  logic [rbd_pkg::DATA_W-1:0] val_r;
  logic                       out_valid_r;
  rbd_pkg::out_item_t         out_r;

  logic                       accept;
  logic [rbd_pkg::PTR_W-1:0]  ram_addr;
  logic                       ram_we;
  logic [rbd_pkg::DATA_W-1:0] ram_rdata;

  assign busy   = (state_r == S_EXEC);
  assign accept = start && !busy;

  rbd_ptr u_ptr (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .dec    (dec)
  );

  // read at accept, write back the following cycle
  assign ram_addr = busy ? op_r.slot : dec.slot;
  assign ram_we   = busy && op_r.wr;

  rbd_ram #(
    .DEPTH_P (rbd_pkg::DEPTH),
    .WIDTH_P (rbd_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (val_r),
    .rdata (ram_rdata)
  );

  // sequencer plus result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    if (accept) begin
      op_r  <= dec;
      val_r <= in_item.value;
    end
    if (busy) begin
      out_r.status <= op_r.status;
      out_r.count  <= op_r.count;
      if (op_r.use_rd) begin
        out_r.data_out <= ram_rdata;          // get/put old value, pops
      end else if (op_r.wr) begin
        out_r.data_out <= val_r;              // pushes echo the word
      end else begin
        out_r.data_out <= '0;                 // errors, unused codes
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

### design/rbd_chk.sv
// ----------------------------------------------------------------------------
// rbd_chk
// Port-level checks on the deque's item/result timing and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire rbd_pkg::out_item_t out_item
);

  // every accepted item yields its result on out_valid
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // a result only follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding busy cycle");

  // error results carry zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != rbd_pkg::ST_OK |-> out_item.data_out == '0)
    else $error("nonzero data on error result");

  // fill never exceeds the store depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.count <= rbd_pkg::CNT_W'(rbd_pkg::DEPTH))
    else $error("count above depth");

  // a push reported full only when the queue is at depth
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == rbd_pkg::ST_FULL
      |-> out_item.count == rbd_pkg::CNT_W'(rbd_pkg::DEPTH))
    else $error("full status below depth");

endmodule

bind ring_buffer_deque rbd_chk u_rbd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
